// ----- rtl/core/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define PSPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while reset is asserted
`define PSPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/psps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package psps_pkg;

  // largest sieve bound the map holds
  localparam int MAX_LIMIT = 65536;

  // field widths
  localparam int NUM_W   = 17;
  localparam int SMALL_W = 16;

  // map memory geometry
  localparam int WORD_W = (MAX_LIMIT >= 64) ? 32 : 4;
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int WORDS  = (MAX_LIMIT + WORD_W - 1) / WORD_W;
  localparam int WIDX_W = $clog2(WORDS);

  // sieve counters
  localparam int P_W   = (NUM_W + 1) / 2;
  localparam int PSQ_W = NUM_W + 1;
  localparam int M_W   = NUM_W + 1;

  localparam logic [NUM_W-1:0]  LIMIT_RST  = NUM_W'(65536);
  localparam logic [WORD_W-1:0] FILL_WORD0 = ~WORD_W'(3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_P_RD,
    ST_P_CHK,
    ST_MARK,
    ST_SEARCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } ctrl_stat_t;

  typedef struct packed {
    logic               found;
    logic [SMALL_W-1:0] smaller;
    logic [NUM_W-1:0]   larger;
    logic               status;
  } result_t;

  typedef struct packed {
    logic              wr_en;
    logic [WIDX_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [WIDX_W-1:0] rd_addr_a;
    logic [WIDX_W-1:0] rd_addr_b;
  } mem_req_t;

  function automatic logic [NUM_W-1:0] eff_bound(input logic [NUM_W-1:0] lim);
    if (int'(lim) > MAX_LIMIT) eff_bound = NUM_W'(MAX_LIMIT);
    else eff_bound = lim;
  endfunction

  function automatic logic [WIDX_W-1:0] word_of(input logic [NUM_W-1:0] n);
    word_of = WIDX_W'(n >> BIT_W);
  endfunction

  function automatic logic [BIT_W-1:0] bit_of(input logic [NUM_W-1:0] n);
    bit_of = n[BIT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/psps_map_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psps_map_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  output logic [WIDTH-1:0] rd_data_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

// ----- rtl/core/psps_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psps_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [psps_pkg::NUM_W-1:0]          in_number,
  input  logic [psps_pkg::NUM_W-1:0]          bound,
  input  logic                                cfg_wr,
  input  logic                                res_take,
  input  logic [psps_pkg::WORD_W-1:0]         rd_data_a,
  input  logic [psps_pkg::WORD_W-1:0]         rd_data_b,
  output psps_pkg::mem_req_t                  mem_req,
  output psps_pkg::ctrl_stat_t                stat,
  output psps_pkg::result_t                   res
);

  import psps_pkg::*;

  state_t state_r, state_nxt;
  logic   map_ready_r;

  logic [NUM_W-1:0]   n_r;
  logic [NUM_W-2:0]   half_r;
  logic [WIDX_W-1:0]  fill_r;
  logic [P_W-1:0]     p_r;
  logic [PSQ_W-1:0]   psq_r;
  logic [M_W-1:0]     m_r;

  // marking stage: read issued last cycle, write back this cycle
  logic               mk_v_r;
  logic [WIDX_W-1:0]  mk_word_r;
  logic [BIT_W-1:0]   mk_bit_r;
  // last word written, for forwarding to a back-to-back hit on the same word
  logic               wb_v_r;
  logic [WIDX_W-1:0]  wb_word_r;
  logic [WORD_W-1:0]  wb_data_r;

  // search stage
  logic [NUM_W-1:0]   i_r;
  logic               s_v_r;
  logic [NUM_W-1:0]   s_i_r;
  logic [BIT_W-1:0]   s_bit_a_r;
  logic [BIT_W-1:0]   s_bit_b_r;

  result_t res_r;

  logic              psq_lt;
  logic              m_lt;
  logic              p_is_prime;
  logic              mark_issue;
  logic              search_issue;
  logic              hit;
  logic              search_miss;
  logic              p_step;
  logic [WORD_W-1:0] mk_base;
  logic [WORD_W-1:0] mk_data;
  logic [NUM_W-1:0]  pair_hi;

  assign psq_lt       = psq_r < PSQ_W'(bound);
  assign m_lt         = m_r < M_W'(bound);
  assign p_is_prime   = rd_data_a[bit_of(NUM_W'(p_r))];
  assign mark_issue   = (state_r == ST_MARK) && m_lt;
  assign search_issue = (state_r == ST_SEARCH) && (i_r <= NUM_W'(half_r));
  assign hit          = s_v_r && rd_data_a[s_bit_a_r] && rd_data_b[s_bit_b_r];
  assign search_miss  = (state_r == ST_SEARCH) && !hit && !search_issue && !s_v_r;
  assign p_step       = ((state_r == ST_P_CHK) && !p_is_prime) ||
                        ((state_r == ST_MARK) && !m_lt);
  assign mk_base      = (wb_v_r && (wb_word_r == mk_word_r)) ? wb_data_r : rd_data_a;
  assign mk_data      = mk_base & ~(WORD_W'(1) << mk_bit_r);
  assign pair_hi      = n_r - i_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_number > bound) state_nxt = ST_DONE;
          else if (!map_ready_r) state_nxt = ST_FILL;
          else state_nxt = ST_SEARCH;
        end
      end
      ST_FILL: begin
        if (fill_r == WIDX_W'(WORDS - 1)) state_nxt = ST_P_RD;
      end
      ST_P_RD: begin
        state_nxt = psq_lt ? ST_P_CHK : ST_SEARCH;
      end
      ST_P_CHK: begin
        state_nxt = p_is_prime ? ST_MARK : ST_P_RD;
      end
      ST_MARK: begin
        if (!m_lt) state_nxt = ST_P_RD;
      end
      ST_SEARCH: begin
        if (hit || search_miss) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    stat.idle      = (state_r == ST_IDLE);
    stat.res_valid = (state_r == ST_DONE);

    mem_req.wr_en     = (state_r == ST_FILL) || mk_v_r;
    mem_req.wr_addr   = (state_r == ST_FILL) ? fill_r : mk_word_r;
    mem_req.wr_data   = mk_data;
    if (state_r == ST_FILL) begin
      mem_req.wr_data = (fill_r == '0) ? FILL_WORD0 : '1;
    end

    mem_req.rd_addr_b = word_of(pair_hi);
    unique case (state_r)
      ST_P_RD:   mem_req.rd_addr_a = word_of(NUM_W'(p_r));
      ST_MARK:   mem_req.rd_addr_a = word_of(NUM_W'(m_r));
      ST_SEARCH: mem_req.rd_addr_a = word_of(i_r);
      default:   mem_req.rd_addr_a = '0;
    endcase
  end

  assign res = res_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      map_ready_r <= 1'b0;
      mk_v_r      <= 1'b0;
      wb_v_r      <= 1'b0;
      s_v_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mk_v_r  <= mark_issue;
      wb_v_r  <= mk_v_r;
      s_v_r   <= search_issue && !hit;
      if (cfg_wr) begin
        map_ready_r <= 1'b0;
      end else if ((state_r == ST_P_RD) && !psq_lt) begin
        map_ready_r <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_valid) begin
      n_r    <= in_number;
      half_r <= in_number[NUM_W-1:1];
    end

    if (state_r != ST_FILL) fill_r <= '0;
    else fill_r <= fill_r + WIDX_W'(1);

    if (state_r == ST_FILL) begin
      p_r   <= P_W'(2);
      psq_r <= PSQ_W'(4);
    end else if (p_step) begin
      p_r   <= p_r + P_W'(1);
      psq_r <= psq_r + (PSQ_W'(p_r) << 1) + PSQ_W'(1);
    end

    if (state_r == ST_P_CHK) begin
      m_r <= M_W'(p_r) << 1;
    end else if (mark_issue) begin
      m_r <= m_r + M_W'(p_r);
    end

    mk_word_r <= word_of(NUM_W'(m_r));
    mk_bit_r  <= bit_of(NUM_W'(m_r));
    wb_word_r <= mk_word_r;
    wb_data_r <= mk_data;

    if (state_r != ST_SEARCH) i_r <= NUM_W'(2);
    else if (search_issue) i_r <= i_r + NUM_W'(1);

    s_i_r     <= i_r;
    s_bit_a_r <= bit_of(i_r);
    s_bit_b_r <= bit_of(pair_hi);

    if ((state_r == ST_IDLE) && in_valid) begin
      res_r.found   <= 1'b0;
      res_r.smaller <= '0;
      res_r.larger  <= '0;
      res_r.status  <= (in_number > bound);
    end else if ((state_r == ST_SEARCH) && hit) begin
      res_r.found   <= 1'b1;
      res_r.smaller <= SMALL_W'(s_i_r);
      res_r.larger  <= n_r - s_i_r;
      res_r.status  <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/prime_sieve_pair_sum_search.sv -----
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+-------------------------------------------
// in_      | in        | in_valid/in_stall   | in_number
// out_     | out       | out_valid/out_stall | out_found, out_smaller_prime,
//          |           |                    | out_larger_prime, out_status
// cfg_     | in        | cfg_valid/cfg_ready | cfg_limit
//
// one query at a time; a number above the bound is answered with no search and no rebuild
// a search tries the candidates one per cycle, from 2 upward to half the number
// the first query in range after reset or a limit write first rebuilds the map: it
// fills all 2048 words, then for each p with p*p below the bound reads p and, for a
// prime, crosses off its multiples from 2p up; the single map write port sets the pace
// rst_n is synchronous, active low; the map memory is never cleared, the rebuild covers it
// a result waits in the output register under out_stall while the next beat is taken
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module prime_sieve_pair_sum_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [psps_pkg::NUM_W-1:0]          in_number,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_found,
  output logic [psps_pkg::SMALL_W-1:0]        out_smaller_prime,
  output logic [psps_pkg::NUM_W-1:0]          out_larger_prime,
  output logic                                out_status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psps_pkg::NUM_W-1:0]          cfg_limit
);

  import psps_pkg::*;

  // limit register and the bound it gives (saturated at the map size)
  logic [NUM_W-1:0] limit_r;
  logic [NUM_W-1:0] bound;
  logic             cfg_wr;

  ctrl_stat_t        stat;
  result_t           res;
  mem_req_t          mem_req;
  logic [WORD_W-1:0] rd_data_a;
  logic [WORD_W-1:0] rd_data_b;
  logic              res_take;

  // output register
  logic               out_valid_r;
  logic               out_found_r;
  logic [SMALL_W-1:0] out_smaller_r;
  logic [NUM_W-1:0]   out_larger_r;
  logic               out_status_r;

  // terms for the checks at the end
  logic found_beat;
  logic range_beat;
  logic in_taken;
  logic pair_ok;
  logic range_clear;

  assign bound     = eff_bound(limit_r);
  // a limit write waits for a quiet input side so it never meets a beat
  assign cfg_ready = stat.idle && !in_valid;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = !stat.idle;

  // the sequencer hands over once the output register is free or being emptied
  assign res_take = stat.res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (cfg_wr) begin
      limit_r <= cfg_limit;
    end
  end

  // fill, sieve and search sequencer
  psps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_number (in_number),
    .bound     (bound),
    .cfg_wr    (cfg_wr),
    .res_take  (res_take),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .mem_req   (mem_req),
    .stat      (stat),
    .res       (res)
  );

  // prime map, one bit per number, packed into words
  psps_map_ram #(
    .DEPTH (WORDS),
    .WIDTH (WORD_W)
  ) u_map (
    .clk       (clk),
    .wr_en     (mem_req.wr_en),
    .wr_addr   (mem_req.wr_addr),
    .wr_data   (mem_req.wr_data),
    .rd_addr_a (mem_req.rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_addr_b (mem_req.rd_addr_b),
    .rd_data_b (rd_data_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_found_r   <= res.found;
      out_smaller_r <= res.smaller;
      out_larger_r  <= res.larger;
      out_status_r  <= res.status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_smaller_prime = out_smaller_r;
  assign out_larger_prime  = out_larger_r;
  assign out_status        = out_status_r;

  assign found_beat  = out_valid && out_found;
  assign range_beat  = out_valid && out_status;
  assign in_taken    = in_valid && !in_stall;
  assign pair_ok     = !out_status && (out_smaller_prime >= SMALL_W'(2)) &&
                       (NUM_W'(out_smaller_prime) <= out_larger_prime);
  assign range_clear = !out_found && (out_smaller_prime == '0) && (out_larger_prime == '0);

  // a found pair is an ordered pair of numbers from two upward, never out of range
  `PSPS_ASSERT_IMP(a_found_pair, clk, rst_n, found_beat, pair_ok, "found beat with bad pair")
  // an out-of-range beat carries no pair
  `PSPS_ASSERT_IMP(a_range_empty, clk, rst_n, range_beat, range_clear, "pair on a range beat")
  // an accepted beat keeps the input side stalled in the next cycle
  `PSPS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_taken, in_stall, "input taken twice")

endmodule

`default_nettype wire

// ----- sim/tb_prime_sieve_pair_sum_search.sv -----
`timescale 1ns / 1ps

module tb_prime_sieve_pair_sum_search;
  import psps_pkg::*;

  // status codes of a result beat
  localparam logic STATUS_OK          = 1'b0;
  localparam logic STATUS_ABOVE_BOUND = 1'b1;

  localparam int SIDE_WAIT_MAX   = 19;
  localparam int RANDOM_PHASES   = 8;
  localparam int BEATS_PER_PHASE = 119;
  localparam int DRAIN_TAIL      = 64;
  // above this bound an odd query may scan thousands of candidates
  localparam int ODD_SCAN_CUTOFF = 1200;

  logic               clk   = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [NUM_W-1:0]   in_number = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_found;
  logic [SMALL_W-1:0] out_smaller_prime;
  logic [NUM_W-1:0]   out_larger_prime;
  logic               out_status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [NUM_W-1:0]   cfg_limit = '0;

  // shadow of the block: prime map, its freshness flag and the limit register
  bit               prime_bits [MAX_LIMIT];
  bit               map_built    = 1'b0;
  logic [NUM_W-1:0] limit_shadow = LIMIT_RST;

  // predicted answers, oldest first
  result_t expected_splits [$];
  int      mismatches = 0;
  // set for phases that run with neither side idling
  bit      calm = 1'b0;

  prime_sieve_pair_sum_search dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_number         (in_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_smaller_prime (out_smaller_prime),
    .out_larger_prime  (out_larger_prime),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_limit         (cfg_limit)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // idle cycles one side spends before its next beat
  function automatic int draw_wait();
    if (calm) return 0;
    return $urandom_range(0, SIDE_WAIT_MAX);
  endfunction

  // sieve of eratosthenes below bnd; entries at or above bnd stay marked
  function automatic void sieve_prime_bits(input int unsigned bnd);
    int unsigned p, m;
    foreach (prime_bits[k]) prime_bits[k] = 1'b1;
    prime_bits[0] = 1'b0;
    prime_bits[1] = 1'b0;
    for (p = 2; p * p < bnd; p++) begin
      if (prime_bits[p]) begin
        for (m = 2 * p; m < bnd; m += p) prime_bits[m] = 1'b0;
      end
    end
    map_built = 1'b1;
  endfunction

  // first pair (i, n - i) of primes with i scanned upward from 2 to n/2
  function automatic result_t split_into_primes(input logic [NUM_W-1:0] number);
    result_t     r;
    int unsigned bnd, n, i;
    r   = '0;
    n   = number;
    // limit saturates at the map size
    bnd = (limit_shadow > MAX_LIMIT) ? MAX_LIMIT : limit_shadow;
    if (n > bnd) begin
      // above the bound: no search, map left as it is
      r.status = STATUS_ABOVE_BOUND;
      return r;
    end
    // first query after reset or a limit write rebuilds the map
    if (!map_built) sieve_prime_bits(bnd);
    // n below 4 leaves the scan empty
    for (i = 2; i <= n / 2 && !r.found; i++) begin
      if (prime_bits[i] && prime_bits[n - i]) begin
        r.found   = 1'b1;
        r.smaller = SMALL_W'(i);
        r.larger  = NUM_W'(n - i);
      end
    end
    r.status = STATUS_OK;
    return r;
  endfunction

  // query mix: mostly inside the bound, some above it, some tiny numbers
  function automatic logic [NUM_W-1:0] pick_number(input int unsigned bnd);
    int unsigned sel, v;
    sel = $urandom_range(0, 99);
    if (sel < 6) return NUM_W'($urandom_range(bnd + 1, 2**NUM_W - 1));
    if (sel < 10) return NUM_W'($urandom_range(0, (bnd < 7) ? bnd : 7));
    v = $urandom_range(0, bnd);
    // long odd scans only now and then once the bound is large
    if (bnd > ODD_SCAN_CUTOFF && sel >= 12) v = v & ~32'd1;
    return NUM_W'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // input and config drivers, all aligned to the rising edge
  // ---------------------------------------------------------------------------

  // one query beat; valid is only lowered when a gap follows, so a back to
  // back beat never sees two assignments to in_valid in one step
  task automatic send_number(input logic [NUM_W-1:0] number);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_number <= number;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_splits.push_back(split_into_primes(number));
  endtask

  // drop valid and hold off until every pending answer has come back
  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    while (expected_splits.size() != 0) @(posedge clk);
  endtask

  // limit write, only ever issued with the block idle
  task automatic write_limit(input logic [NUM_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_limit <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    limit_shadow = value;
    map_built    = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result checker and output back-pressure
  // ---------------------------------------------------------------------------

  // after each taken beat the sink stalls for a freshly drawn number of cycles
  initial begin : result_check
    result_t want;
    int      hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_splits.size() == 0) begin
          $error("result beat with nothing pending: found %0d smaller %0d larger %0d status %0d",
                 out_found, out_smaller_prime, out_larger_prime, out_status);
          mismatches++;
        end else begin
          want = expected_splits.pop_front();
          if (out_found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_found);
            mismatches++;
          end
          if (out_smaller_prime !== want.smaller) begin
            $error("smaller_prime: expected %0d, got %0d", want.smaller, out_smaller_prime);
            mismatches++;
          end
          if (out_larger_prime !== want.larger) begin
            $error("larger_prime: expected %0d, got %0d", want.larger, out_larger_prime);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
        end
        hold = draw_wait();
      end else if (hold > 0) begin
        hold--;
      end
      out_stall <= (hold != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset bound: small numbers, the top of the map, and beats above it
  task automatic test_default_bound();
    send_number(NUM_W'(0));
    send_number(NUM_W'(1));
    send_number(NUM_W'(2));
    send_number(NUM_W'(3));
    send_number(NUM_W'(4));
    send_number(NUM_W'(5));
    send_number(NUM_W'(6));
    send_number(NUM_W'(65534));
    // odd with no pair: full scan to n/2
    send_number(NUM_W'(65535));
    send_number(NUM_W'(MAX_LIMIT));
    send_number(NUM_W'(MAX_LIMIT + 1));
    send_number(NUM_W'(2**NUM_W - 1));
    settle();
  endtask

  // all-ones limit saturates at the map size
  task automatic test_saturated_limit();
    write_limit(NUM_W'(2**NUM_W - 1));
    send_number(NUM_W'(MAX_LIMIT));
    send_number(NUM_W'(MAX_LIMIT + 1));
    settle();
  endtask

  // limits below 4: nothing can be split, anything larger is out of range
  task automatic test_tiny_limits();
    write_limit(NUM_W'(3));
    send_number(NUM_W'(0));
    send_number(NUM_W'(3));
    send_number(NUM_W'(4));
    settle();
    write_limit(NUM_W'(0));
    send_number(NUM_W'(0));
    send_number(NUM_W'(1));
    settle();
  endtask

  // smallest limit with a split: 4 itself splits as 2 + 2
  task automatic test_lowest_limit();
    write_limit(NUM_W'(4));
    send_number(NUM_W'(4));
    send_number(NUM_W'(5));
    settle();
  endtask

  // odd numbers with and without a pair, the bound itself and one above it
  task automatic test_unsplittable_numbers();
    write_limit(NUM_W'(1000));
    send_number(NUM_W'(9));
    send_number(NUM_W'(11));
    send_number(NUM_W'(27));
    send_number(NUM_W'(1000));
    send_number(NUM_W'(1001));
    settle();
  endtask

  // phases of random queries, each under its own limit
  task automatic test_random_phases();
    logic [NUM_W-1:0] lim;
    int unsigned      bnd;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       lim = NUM_W'(MAX_LIMIT);
        1:       lim = NUM_W'($urandom_range(ODD_SCAN_CUTOFF + 1, 20000));
        2:       lim = NUM_W'($urandom_range(4, 16));
        default: lim = NUM_W'($urandom_range(4, ODD_SCAN_CUTOFF));
      endcase
      // every third phase runs flat out
      calm = (ph % 3 == 2);
      write_limit(lim);
      bnd = (lim > MAX_LIMIT) ? MAX_LIMIT : lim;
      repeat (BEATS_PER_PHASE) begin
        send_number(pick_number(bnd));
        // now and then the sender waits for the pipe to empty
        if ($urandom_range(0, 39) == 0) settle();
      end
      settle();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_bound();
    test_saturated_limit();
    test_tiny_limits();
    test_lowest_limit();
    test_unsplittable_numbers();
    test_random_phases();
    settle();
    // a short tail to catch any stray beat
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0) begin
      $display("[prime_sieve_pair_sum_search] OK");
    end else begin
      $display("[prime_sieve_pair_sum_search] ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run including full map rebuilds
  initial begin
    #80_000_000;
    $display("[prime_sieve_pair_sum_search] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/psps_pkg.sv
rtl/core/psps_map_ram.sv
rtl/core/psps_ctrl.sv
rtl/core/prime_sieve_pair_sum_search.sv
sim/tb_prime_sieve_pair_sum_search.sv
